// ===== sv/cwsr_pkg.sv =====
`default_nettype none

package cwsr_pkg;

    // field and register widths fixed by the interface
    localparam int ADDR_W    = 32;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int WS_SIZE_W = 5;
    localparam int SLOT_W    = 4;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_WS_SIZE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_START   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_MAX     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STACK_BOTTOM = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STACK_TOP    = 3'd4;

    // working set size after reset
    localparam logic [WS_SIZE_W-1:0] WS_SIZE_RST = 5'd16;

    // legal user address ranges
    typedef struct packed {
        logic [ADDR_W-1:0] heap_start;
        logic [ADDR_W-1:0] heap_max;
        logic [ADDR_W-1:0] stack_bottom;
        logic [ADDR_W-1:0] stack_top;
    } t_ranges;

    // one result word
    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [ADDR_W-1:0] evicted_page;
        logic              write_back;
        logic              installed;
        logic [SLOT_W-1:0] installed_slot;
        logic              illegal;
    } t_result;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_LOOK     = 6'b000010,
        S_LOOK_END = 6'b000100,
        S_SCAN     = 6'b001000,
        S_SWEEP    = 6'b010000,
        S_EVICT    = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ===== sv/cwsr_range_chk.sv =====
`default_nettype none

module cwsr_range_chk (
    input  wire logic [cwsr_pkg::ADDR_W-1:0] i_address,
    input  wire logic                        i_in_page_file,
    input  wire cwsr_pkg::t_ranges           i_ranges,
    output logic                             o_legal
);

    logic w_in_heap;
    logic w_in_stack;

    // address inside heap or stack window
    assign w_in_heap  = (i_address >= i_ranges.heap_start) && (i_address <= i_ranges.heap_max);
    assign w_in_stack = (i_address >= i_ranges.stack_bottom) &&
                        (i_address <= i_ranges.stack_top);

    assign o_legal = i_in_page_file || w_in_heap || w_in_stack;

endmodule

`default_nettype wire

// ===== sv/clock_working_set_replacer_core.sv =====
// Clock working-set page replacer.
// Command channel: an item (action, address, is_write, in_page_file) is taken at
// a rising edge with start high and busy low; busy stays high while it is worked.
// Result channel: o_strobe is high for exactly one cycle with the result word on
// the o_ ports; the receiver cannot stall, so the word is lost if not sampled.
// Config port: i_cfg_wr_en, i_cfg_addr, i_cfg_wdata write a register at once;
// write only while busy is low and no result is pending.
// Sequence, with S the effective working set size:
//   access event: the first S slots are read one slot per cycle from the page
//   memory, whose read data is registered, and compared with the page
//   fault with a free slot: the first empty slot is found and the page installed
//   fault with a full set: the scan finds no free slot, the hand sweeps to an
//   unused entry, and that entry is evicted and its slot refilled.
// One item is in flight at a time; busy falls in the strobe cycle, so the next
// start may be taken there. The page memory has one write port and one registered
// read port, one write and one read per cycle, and sets the per-slot pace.
// Reset clears all valid, used and modified marks and the hand, and loads
// ws_size 16 and zero address ranges; no clearing pass is needed.
`default_nettype none

module clock_working_set_replacer_core #(
    parameter int WS_DEPTH  = 16,
    parameter int PAGE_BITS = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_action,
    input  wire logic [cwsr_pkg::ADDR_W-1:0]      i_address,
    input  wire logic                             i_is_write,
    input  wire logic                             i_in_page_file,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [cwsr_pkg::REG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [cwsr_pkg::DATA_W-1:0]      i_cfg_wdata,
    output logic                                  o_strobe,
    output logic                                  o_hit,
    output logic                                  o_evicted,
    output logic [cwsr_pkg::ADDR_W-1:0]           o_evicted_page,
    output logic                                  o_write_back,
    output logic                                  o_installed,
    output logic [cwsr_pkg::SLOT_W-1:0]           o_installed_slot,
    output logic                                  o_illegal
);

    localparam int IW     = $clog2(WS_DEPTH);
    localparam int SW     = $clog2(WS_DEPTH + 1);
    localparam int VW     = SW + 1;
    localparam int PW     = cwsr_pkg::ADDR_W - PAGE_BITS;
    localparam int SLOT_W = cwsr_pkg::SLOT_W;

    // configuration registers
    logic [cwsr_pkg::WS_SIZE_W-1:0] r_ws_size;
    cwsr_pkg::t_ranges              r_ranges;

    // control state
    cwsr_pkg::t_state     r_state, n_state;
    logic [WS_DEPTH-1:0]  r_valid, n_valid;
    logic [WS_DEPTH-1:0]  r_used, n_used;
    logic [WS_DEPTH-1:0]  r_mod, n_mod;
    logic [IW-1:0]        r_hand, n_hand;
    logic                 r_strobe, n_strobe;
    logic                 r_pv, n_pv;

    // per-item working registers
    logic [SW-1:0]        r_size, n_size;
    logic [IW-1:0]        r_last, n_last;
    logic [IW-1:0]        r_idx, n_idx;
    logic [IW-1:0]        r_pidx, n_pidx;
    logic [IW-1:0]        r_h, n_h;
    logic [VW-1:0]        r_visit, n_visit;
    logic [PW-1:0]        r_page, n_page;
    logic                 r_write, n_write;
    logic                 r_legal, n_legal;
    cwsr_pkg::t_result    r_res, n_res;

    // page memory
    logic [PW-1:0]        m_page [WS_DEPTH];
    logic [PW-1:0]        r_rd_data;
    logic                 w_mem_we;
    logic [IW-1:0]        w_mem_wa;
    logic [IW-1:0]        w_mem_ra;

    logic [31:0]          w_ws32;
    logic [31:0]          w_eff32;
    logic [SW-1:0]        w_eff;
    logic [IW-1:0]        w_last;
    logic                 w_legal;
    logic                 w_install;
    logic [IW-1:0]        w_slot;

    // legality of the incoming address
    cwsr_range_chk u_range_chk (
        .i_address      (i_address),
        .i_in_page_file (i_in_page_file),
        .i_ranges       (r_ranges),
        .o_legal        (w_legal)
    );

    // effective size, clamped to 1..WS_DEPTH
    assign w_ws32  = 32'(r_ws_size);
    assign w_eff32 = (w_ws32 == 32'd0) ? 32'd1 :
                     (w_ws32 > 32'(WS_DEPTH)) ? 32'(WS_DEPTH) : w_ws32;
    assign w_eff   = SW'(w_eff32);
    assign w_last  = IW'(w_eff32 - 32'd1);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws_size <= cwsr_pkg::WS_SIZE_RST;
            r_ranges  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                cwsr_pkg::REG_WS_SIZE:      r_ws_size <= i_cfg_wdata[cwsr_pkg::WS_SIZE_W-1:0];
                cwsr_pkg::REG_HEAP_START:   r_ranges.heap_start   <= i_cfg_wdata;
                cwsr_pkg::REG_HEAP_MAX:     r_ranges.heap_max     <= i_cfg_wdata;
                cwsr_pkg::REG_STACK_BOTTOM: r_ranges.stack_bottom <= i_cfg_wdata;
                cwsr_pkg::REG_STACK_TOP:    r_ranges.stack_top    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_used    = r_used;
        n_mod     = r_mod;
        n_hand    = r_hand;
        n_strobe  = 1'b0;
        n_pv      = r_pv;
        n_size    = r_size;
        n_last    = r_last;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_h       = r_h;
        n_visit   = r_visit;
        n_page    = r_page;
        n_write   = r_write;
        n_legal   = r_legal;
        n_res     = r_res;
        w_mem_we  = 1'b0;
        w_mem_wa  = r_idx;
        w_mem_ra  = r_idx;
        w_install = 1'b0;
        w_slot    = r_idx;

        case (r_state)
            cwsr_pkg::S_IDLE: begin
                if (start) begin
                    n_size  = w_eff;
                    n_last  = w_last;
                    n_page  = i_address[cwsr_pkg::ADDR_W-1:PAGE_BITS];
                    n_write = i_is_write;
                    n_legal = w_legal;
                    n_res   = '0;
                    n_idx   = '0;
                    n_pv    = 1'b0;
                    n_visit = '0;
                    n_state = i_action ? cwsr_pkg::S_SCAN : cwsr_pkg::S_LOOK;
                end
            end

            // lookup: issue one slot per cycle, compare the slot read last cycle
            cwsr_pkg::S_LOOK, cwsr_pkg::S_LOOK_END: begin
                if (r_pv && r_valid[r_pidx] && (r_rd_data == r_page)) begin
                    n_res.hit      = 1'b1;
                    n_used[r_pidx] = 1'b1;
                    if (r_write) begin
                        n_mod[r_pidx] = 1'b1;
                    end
                end
                if (r_state == cwsr_pkg::S_LOOK) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    if (r_idx == r_last) begin
                        n_state = cwsr_pkg::S_LOOK_END;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_strobe = 1'b1;
                    n_state  = cwsr_pkg::S_IDLE;
                end
            end

            // search for the first empty slot and install there; if none, start the hand sweep
            cwsr_pkg::S_SCAN: begin
                if (!r_valid[r_idx]) begin
                    w_slot    = r_idx;
                    w_install = r_legal;
                    n_res.illegal = !r_legal;
                    n_strobe  = 1'b1;
                    n_state   = cwsr_pkg::S_IDLE;
                end else if (r_idx == r_last) begin
                    n_h     = (r_hand > r_last) ? '0 : r_hand;
                    n_state = cwsr_pkg::S_SWEEP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // hand sweep: clear used marks until an unused entry is found or the visits reach twice the size
            cwsr_pkg::S_SWEEP: begin
                w_mem_ra = r_h;
                if (!r_used[r_h]) begin
                    n_state = cwsr_pkg::S_EVICT;
                end else begin
                    n_used[r_h] = 1'b0;
                    n_h         = (r_h == r_last) ? '0 : r_h + 1'b1;
                    n_visit     = r_visit + 1'b1;
                    if (n_visit == {r_size, 1'b0}) begin
                        n_hand   = n_h;
                        n_strobe = 1'b1;
                        n_state  = cwsr_pkg::S_IDLE;
                    end
                end
            end

            // evict the entry under the hand, its slot is then the only free one
            cwsr_pkg::S_EVICT: begin
                n_res.evicted      = 1'b1;
                n_res.evicted_page = {r_rd_data, {PAGE_BITS{1'b0}}};
                n_res.write_back   = r_mod[r_h];
                n_valid[r_h]       = 1'b0;
                n_mod[r_h]         = 1'b0;
                n_hand             = r_h;
                w_slot             = r_h;
                w_install          = r_legal;
                n_res.illegal      = !r_legal;
                n_strobe           = 1'b1;
                n_state            = cwsr_pkg::S_IDLE;
            end

            default: begin
                n_state = cwsr_pkg::S_IDLE;
            end
        endcase

        // install the faulting page
        if (w_install) begin
            w_mem_we             = 1'b1;
            w_mem_wa             = w_slot;
            n_valid[w_slot]      = 1'b1;
            n_used[w_slot]       = 1'b0;
            n_mod[w_slot]        = 1'b0;
            n_res.installed      = 1'b1;
            n_res.installed_slot = SLOT_W'(w_slot);
            n_hand               = (w_slot == r_last) ? '0 : w_slot + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cwsr_pkg::S_IDLE;
            r_valid  <= '0;
            r_used   <= '0;
            r_mod    <= '0;
            r_hand   <= '0;
            r_strobe <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_used   <= n_used;
            r_mod    <= n_mod;
            r_hand   <= n_hand;
            r_strobe <= n_strobe;
            r_pv     <= n_pv;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_last  <= n_last;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_h     <= n_h;
        r_visit <= n_visit;
        r_page  <= n_page;
        r_write <= n_write;
        r_legal <= n_legal;
        r_res   <= n_res;
    end

    // page memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            m_page[w_mem_wa] <= r_page;
        end
        r_rd_data <= m_page[w_mem_ra];
    end

    // result word
    assign busy             = (r_state != cwsr_pkg::S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_hit            = r_res.hit;
    assign o_evicted        = r_res.evicted;
    assign o_evicted_page   = r_res.evicted_page;
    assign o_write_back     = r_res.write_back;
    assign o_installed      = r_res.installed;
    assign o_installed_slot = r_res.installed_slot;
    assign o_illegal        = r_res.illegal;

endmodule

`default_nettype wire
